// ===== rtl/view_frustum_box_culler_defines.svh =====
// Assertion macros used by the view frustum box culler controller.
`ifndef VIEW_FRUSTUM_BOX_CULLER_DEFINES_SVH
`define VIEW_FRUSTUM_BOX_CULLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFBC_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("vfbc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VFBC_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("vfbc: next-cycle check failed");

`endif

// ===== rtl/vfbc_pkg.sv =====
// Package with the types, constants and helpers of the view frustum box culler.
`timescale 1ns / 1ps

package vfbc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ACC_W         = 66;
	localparam int PLANES        = 6;
	localparam int SQRT_STEPS    = 32;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAT,
		ST_EXT,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_ZERO,
		ST_TEST,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_MAT,
		MUL_SQ,
		MUL_TEST
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_SET,
		ACC_ADD,
		ACC_LOAD_D
	} acc_op_t;

	typedef struct packed {
		logic       capture;
		logic       sat_clr;
		logic       deg_clr;
		logic       deg_set;
		logic       vis_init;
		logic       load_wr;
		mul_sel_t   mul_sel;
		logic       mul_en;
		acc_op_t    acc_op;
		logic       clip_wr;
		logic       co_lat;
		logic       co_wr;
		logic       sqrt_start;
		logic       sqrt_step;
		logic       div_start;
		logic       div_step;
		logic       plane_wr;
		logic       plane_zero;
		logic       vis_check;
		logic       out_load;
		logic [3:0] elem;
		logic [2:0] plane;
		logic [1:0] sub;
	} dp_cmd_t;

	typedef struct packed {
		logic len_zero;
	} dp_status_t;

	// Column of the clip matrix that is combined with column 3 for a plane.
	function automatic logic [1:0] plane_row(input logic [2:0] p);
		return p[2:1];
	endfunction

	// Planes that add the selected column; the others subtract it.
	function automatic logic plane_adds(input logic [2:0] p);
		logic r;
		case (p) inside
			3'd1, 3'd2, 3'd5: r = 1'b1;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/view_frustum_box_culler.sv =====
// Top level of the view frustum box culler: controller and datapath.
`timescale 1ns / 1ps

// Usage: the input channel carries one item per handshake (in_valid high, in_stall low).
// cmd selects a matrix element load, a plane build from the two matrices, or a box test.
// Every item yields exactly one result item on the output channel (out_valid, out_stall).
// Items are handled one at a time; in_stall is low only while the controller is idle.
// Work per item: a load writes one matrix element, an unused command goes straight to
//   the result, a box test runs 6 planes of 6 steps through the shared multiply-accumulate,
//   and a build runs the 64 matrix products, then for each plane the 32-step square root
//   and, unless the normal is zero, the bit-serial divider.
// The next item is taken in the cycle after the result is loaded.
// A finished result waits in the output register while the next item is taken in;
// a held out_stall then holds the controller in its final step until the slot frees.
// Reset clears both matrices, the plane table and the degenerate flag, so every box is
// culled until a build has run.

module view_frustum_box_culler #(
	parameter int FRAC_BITS = vfbc_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic               matrix_select,
	input  logic [3:0]         element_index,
	input  logic signed [31:0] element_value,
	input  logic signed [31:0] box_min_x,
	input  logic signed [31:0] box_min_y,
	input  logic signed [31:0] box_min_z,
	input  logic signed [31:0] box_max_x,
	input  logic signed [31:0] box_max_y,
	input  logic signed [31:0] box_max_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               in_view,
	output logic               degenerate_plane,
	output logic               saturated
);

	vfbc_pkg::dp_cmd_t    ctl;
	vfbc_pkg::dp_status_t status;

	vfbc_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ctl      (ctl),
		.status   (status)
	);

	vfbc_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.status          (status),
		.matrix_select   (matrix_select),
		.element_index   (element_index),
		.element_value   (element_value),
		.box_min_x       (box_min_x),
		.box_min_y       (box_min_y),
		.box_min_z       (box_min_z),
		.box_max_x       (box_max_x),
		.box_max_y       (box_max_y),
		.box_max_z       (box_max_z),
		.in_view         (in_view),
		.degenerate_plane(degenerate_plane),
		.saturated       (saturated)
	);

endmodule

// ===== rtl/vfbc_dp.sv =====
// Datapath of the view frustum box culler: stores, multiply-accumulate, square root, divider.
`timescale 1ns / 1ps

module vfbc_dp #(
	parameter int FRAC_BITS = vfbc_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vfbc_pkg::dp_cmd_t    ctl,
	output vfbc_pkg::dp_status_t status,
	input  logic                 matrix_select,
	input  logic [3:0]           element_index,
	input  logic signed [31:0]   element_value,
	input  logic signed [31:0]   box_min_x,
	input  logic signed [31:0]   box_min_y,
	input  logic signed [31:0]   box_min_z,
	input  logic signed [31:0]   box_max_x,
	input  logic signed [31:0]   box_max_y,
	input  logic signed [31:0]   box_max_z,
	output logic                 in_view,
	output logic                 degenerate_plane,
	output logic                 saturated
);

	localparam int ACC_W = vfbc_pkg::ACC_W;
	localparam int DW    = 32 + FRAC_BITS;

	logic signed [31:0] mv_q [16];
	logic signed [31:0] pr_q [16];
	logic signed [31:0] clip_q [16];
	logic signed [31:0] plane_q [24];
	logic signed [31:0] co_q [4];

	logic               sel_q;
	logic [3:0]         idx_q;
	logic signed [31:0] val_q;
	logic signed [31:0] lo_q [3];
	logic signed [31:0] hi_q [3];

	logic signed [63:0]      prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [31:0]      co_a_q;
	logic [63:0]             sq_val_q;
	logic [35:0]             sq_rem_q;
	logic [31:0]             root_q;
	logic [DW-1:0]           dvd_q;
	logic [31:0]             drem_q;
	logic                    neg_q;
	logic                    sat_q;
	logic                    deg_q;
	logic                    vis_q;
	logic                    in_view_q;
	logic                    deg_out_q;
	logic                    sat_out_q;

	logic [4:0]              pidx;
	logic signed [31:0]      coef;
	logic signed [31:0]      ma;
	logic signed [31:0]      mb;
	logic signed [31:0]      lo_v;
	logic signed [31:0]      hi_v;
	logic signed [31:0]      pick;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] acc_sh;
	logic [32:0]             clip_res;
	logic [3:0]              clip_rd;
	logic signed [31:0]      clip_b;
	logic signed [32:0]      co_sum;
	logic [32:0]             co_res;
	logic [35:0]             rem_sh;
	logic [35:0]             trial;
	logic [32:0]             r2;
	logic                    ge;
	logic signed [31:0]      x_src;
	logic [31:0]             mag;
	logic [DW-32:0]          q_hi;
	logic                    pos_sat;
	logic                    neg_sat;
	logic [31:0]             q_val;
	logic                    q_sat;

	// Clamp a wide signed value to 32 bits; the top bit of the result flags a clamp.
	function automatic logic [32:0] sat_acc(input logic [ACC_W-1:0] v);
		logic all_ones;
		logic all_zeros;
		logic [32:0] r;
		all_ones  = &v[ACC_W-1:31];
		all_zeros = ~|v[ACC_W-1:31];
		if (all_ones || all_zeros) begin
			r = {1'b0, v[31:0]};
		end else if (v[ACC_W-1]) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b1, 32'h7fff_ffff};
		end
		return r;
	endfunction

	assign pidx = {ctl.plane, ctl.sub};
	assign coef = plane_q[pidx];

	always_comb begin
		case (ctl.sub)
			2'd0: begin
				lo_v = lo_q[0];
				hi_v = hi_q[0];
			end
			2'd1: begin
				lo_v = lo_q[1];
				hi_v = hi_q[1];
			end
			2'd2: begin
				lo_v = lo_q[2];
				hi_v = hi_q[2];
			end
			default: begin
				lo_v = '0;
				hi_v = '0;
			end
		endcase
	end

	// The corner that maximizes the plane value takes the larger bound where the
	// coefficient is not negative and the smaller bound where it is.
	always_comb begin
		if (coef[31]) begin
			pick = (lo_v < hi_v) ? lo_v : hi_v;
		end else begin
			pick = (lo_v > hi_v) ? lo_v : hi_v;
		end
	end

	always_comb begin
		case (ctl.mul_sel)
			vfbc_pkg::MUL_MAT: begin
				ma = mv_q[{ctl.elem[3:2], ctl.sub}];
				mb = pr_q[{ctl.sub, ctl.elem[1:0]}];
			end
			vfbc_pkg::MUL_SQ: begin
				ma = co_q[ctl.sub];
				mb = co_q[ctl.sub];
			end
			vfbc_pkg::MUL_TEST: begin
				ma = coef;
				mb = pick;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod_ext = {{(ACC_W-64){prod_q[63]}}, prod_q};
	assign acc_sh   = acc_q >>> FRAC_BITS;
	assign clip_res = sat_acc(acc_sh);

	assign clip_rd = ctl.co_wr ? {ctl.sub, vfbc_pkg::plane_row(ctl.plane)} : {ctl.sub, 2'd3};
	assign clip_b  = clip_q[clip_rd];
	assign co_sum  = vfbc_pkg::plane_adds(ctl.plane) ?
		({co_a_q[31], co_a_q} + {clip_b[31], clip_b}) :
		({co_a_q[31], co_a_q} - {clip_b[31], clip_b});
	assign co_res  = sat_acc({{(ACC_W-33){co_sum[32]}}, co_sum});

	assign rem_sh = {sq_rem_q[33:0], sq_val_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};

	assign r2 = {drem_q, dvd_q[DW-1]};
	assign ge = r2 >= {1'b0, root_q};

	assign x_src = co_q[ctl.sub];
	assign mag   = x_src[31] ? (~x_src + 32'd1) : x_src;

	assign q_hi    = dvd_q[DW-1:31];
	assign pos_sat = |q_hi;
	assign neg_sat = (q_hi > (DW-31)'(1)) || ((q_hi == (DW-31)'(1)) && (|dvd_q[30:0]));

	always_comb begin
		if (neg_q) begin
			q_sat = neg_sat;
			q_val = neg_sat ? 32'h8000_0000 : (~dvd_q[31:0] + 32'd1);
		end else begin
			q_sat = pos_sat;
			q_val = pos_sat ? 32'h7fff_ffff : dvd_q[31:0];
		end
	end

	assign status.len_zero = (root_q == '0);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			sel_q <= matrix_select;
			idx_q <= element_index;
			val_q <= element_value;
			lo_q[0] <= box_min_x;
			lo_q[1] <= box_min_y;
			lo_q[2] <= box_min_z;
			hi_q[0] <= box_max_x;
			hi_q[1] <= box_max_y;
			hi_q[2] <= box_max_z;
		end
		if (ctl.mul_en) begin
			prod_q <= ma * mb;
		end
		case (ctl.acc_op)
			vfbc_pkg::ACC_SET:    acc_q <= prod_ext;
			vfbc_pkg::ACC_ADD:    acc_q <= acc_q + prod_ext;
			vfbc_pkg::ACC_LOAD_D: acc_q <= {{(ACC_W-32-FRAC_BITS){coef[31]}}, coef,
				{FRAC_BITS{1'b0}}};
			default:              acc_q <= acc_q;
		endcase
		if (ctl.clip_wr) begin
			clip_q[ctl.elem] <= clip_res[31:0];
		end
		if (ctl.co_lat) begin
			co_a_q <= clip_b;
		end
		if (ctl.co_wr) begin
			co_q[ctl.sub] <= co_res[31:0];
		end
		if (ctl.sqrt_start) begin
			sq_val_q <= acc_q[63:0];
			sq_rem_q <= '0;
			root_q   <= '0;
		end else if (ctl.sqrt_step) begin
			sq_val_q <= {sq_val_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				sq_rem_q <= rem_sh - trial;
				root_q   <= {root_q[30:0], 1'b1};
			end else begin
				sq_rem_q <= rem_sh;
				root_q   <= {root_q[30:0], 1'b0};
			end
		end
		if (ctl.div_start) begin
			dvd_q  <= {mag, {FRAC_BITS{1'b0}}};
			drem_q <= '0;
			neg_q  <= x_src[31];
		end else if (ctl.div_step) begin
			drem_q <= ge ? 32'(r2 - {1'b0, root_q}) : r2[31:0];
			dvd_q  <= {dvd_q[DW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mv_q[i] <= '0;
				pr_q[i] <= '0;
			end
		end else if (ctl.load_wr) begin
			if (sel_q) begin
				pr_q[idx_q] <= val_q;
			end else begin
				mv_q[idx_q] <= val_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 24; i++) begin
				plane_q[i] <= '0;
			end
		end else if (ctl.plane_wr) begin
			plane_q[pidx] <= ctl.plane_zero ? 32'd0 : q_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q     <= 1'b0;
			deg_q     <= 1'b0;
			vis_q     <= 1'b0;
			in_view_q <= 1'b0;
			deg_out_q <= 1'b0;
			sat_out_q <= 1'b0;
		end else begin
			if (ctl.sat_clr) begin
				sat_q <= 1'b0;
			end else if ((ctl.clip_wr && clip_res[32]) || (ctl.co_wr && co_res[32]) ||
				(ctl.plane_wr && !ctl.plane_zero && q_sat)) begin
				sat_q <= 1'b1;
			end
			if (ctl.deg_clr) begin
				deg_q <= 1'b0;
			end else if (ctl.deg_set) begin
				deg_q <= 1'b1;
			end
			if (ctl.capture) begin
				vis_q <= ctl.vis_init;
			end else if (ctl.vis_check && (acc_q[ACC_W-1] || (acc_q == '0))) begin
				vis_q <= 1'b0;
			end
			if (ctl.out_load) begin
				in_view_q <= vis_q;
				deg_out_q <= deg_q;
				sat_out_q <= sat_q;
			end
		end
	end

	assign in_view          = in_view_q;
	assign degenerate_plane = deg_out_q;
	assign saturated        = sat_out_q;

endmodule

// ===== rtl/vfbc_ctrl.sv =====
// Controller of the view frustum box culler: sequences loads, builds and box tests.
`timescale 1ns / 1ps
`include "view_frustum_box_culler_defines.svh"

module vfbc_ctrl #(
	parameter int FRAC_BITS = vfbc_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           cmd,
	output logic                 out_valid,
	input  logic                 out_stall,
	output vfbc_pkg::dp_cmd_t    ctl,
	input  vfbc_pkg::dp_status_t status
);

	localparam int DIV_STEPS = 32 + FRAC_BITS;
	localparam int ITER_W    = $clog2(DIV_STEPS + 2);

	vfbc_pkg::state_t state_q;
	vfbc_pkg::state_t state_d;
	logic [2:0]        step_q;
	logic [3:0]        elem_q;
	logic [2:0]        plane_q;
	logic [1:0]        sub_q;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic              last_plane;
	logic              div_last;

	assign last_plane = (plane_q == 3'(vfbc_pkg::PLANES - 1));
	assign div_last   = (iter_q == ITER_W'(DIV_STEPS + 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vfbc_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (vfbc_pkg::cmd_t'(cmd))
						vfbc_pkg::CMD_LOAD:  state_d = vfbc_pkg::ST_LOAD;
						vfbc_pkg::CMD_BUILD: state_d = vfbc_pkg::ST_MAT;
						vfbc_pkg::CMD_TEST:  state_d = vfbc_pkg::ST_TEST;
						default:             state_d = vfbc_pkg::ST_DONE;
					endcase
				end
			end
			vfbc_pkg::ST_LOAD: state_d = vfbc_pkg::ST_DONE;
			vfbc_pkg::ST_MAT: begin
				if (step_q == 3'd5 && elem_q == 4'd15) begin
					state_d = vfbc_pkg::ST_EXT;
				end
			end
			vfbc_pkg::ST_EXT: begin
				if (step_q == 3'd7) begin
					state_d = vfbc_pkg::ST_SQ;
				end
			end
			vfbc_pkg::ST_SQ: begin
				if (step_q == 3'd3) begin
					state_d = vfbc_pkg::ST_SQRT;
				end
			end
			vfbc_pkg::ST_SQRT: begin
				if (iter_q == ITER_W'(vfbc_pkg::SQRT_STEPS)) begin
					state_d = vfbc_pkg::ST_DIV;
				end
			end
			vfbc_pkg::ST_DIV: begin
				if (iter_q == '0 && status.len_zero) begin
					state_d = vfbc_pkg::ST_ZERO;
				end else if (div_last && sub_q == 2'd3) begin
					state_d = last_plane ? vfbc_pkg::ST_DONE : vfbc_pkg::ST_EXT;
				end
			end
			vfbc_pkg::ST_ZERO: begin
				if (sub_q == 2'd3) begin
					state_d = last_plane ? vfbc_pkg::ST_DONE : vfbc_pkg::ST_EXT;
				end
			end
			vfbc_pkg::ST_TEST: begin
				if (step_q == 3'd5 && last_plane) begin
					state_d = vfbc_pkg::ST_DONE;
				end
			end
			vfbc_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = vfbc_pkg::ST_IDLE;
				end
			end
			default: state_d = vfbc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			vfbc_pkg::ST_IDLE: begin
				in_stall     = 1'b0;
				ctl.capture  = in_valid;
				ctl.sat_clr  = in_valid;
				ctl.deg_clr  = in_valid && (vfbc_pkg::cmd_t'(cmd) == vfbc_pkg::CMD_BUILD);
				ctl.vis_init = (vfbc_pkg::cmd_t'(cmd) == vfbc_pkg::CMD_TEST);
			end
			vfbc_pkg::ST_LOAD: ctl.load_wr = 1'b1;
			vfbc_pkg::ST_MAT: begin
				ctl.mul_sel = vfbc_pkg::MUL_MAT;
				ctl.elem    = elem_q;
				ctl.sub     = step_q[1:0];
				ctl.mul_en  = (step_q <= 3'd3);
				if (step_q == 3'd1) begin
					ctl.acc_op = vfbc_pkg::ACC_SET;
				end else if (step_q >= 3'd2 && step_q <= 3'd4) begin
					ctl.acc_op = vfbc_pkg::ACC_ADD;
				end
				ctl.clip_wr = (step_q == 3'd5);
			end
			vfbc_pkg::ST_EXT: begin
				ctl.plane  = plane_q;
				ctl.sub    = step_q[2:1];
				ctl.co_lat = !step_q[0];
				ctl.co_wr  = step_q[0];
			end
			vfbc_pkg::ST_SQ: begin
				ctl.mul_sel = vfbc_pkg::MUL_SQ;
				ctl.sub     = step_q[1:0];
				ctl.mul_en  = (step_q <= 3'd2);
				if (step_q == 3'd1) begin
					ctl.acc_op = vfbc_pkg::ACC_SET;
				end else if (step_q >= 3'd2) begin
					ctl.acc_op = vfbc_pkg::ACC_ADD;
				end
			end
			vfbc_pkg::ST_SQRT: begin
				ctl.sqrt_start = (iter_q == '0);
				ctl.sqrt_step  = (iter_q != '0);
			end
			vfbc_pkg::ST_DIV: begin
				ctl.plane = plane_q;
				ctl.sub   = sub_q;
				if (iter_q == '0) begin
					ctl.deg_set   = status.len_zero;
					ctl.div_start = !status.len_zero;
				end else if (div_last) begin
					ctl.plane_wr = 1'b1;
				end else begin
					ctl.div_step = 1'b1;
				end
			end
			vfbc_pkg::ST_ZERO: begin
				ctl.plane      = plane_q;
				ctl.sub        = sub_q;
				ctl.plane_wr   = 1'b1;
				ctl.plane_zero = 1'b1;
			end
			vfbc_pkg::ST_TEST: begin
				ctl.plane   = plane_q;
				ctl.mul_sel = vfbc_pkg::MUL_TEST;
				if (step_q == 3'd0) begin
					// The offset term is read first so the plane table has one read per cycle.
					ctl.sub    = 2'd3;
					ctl.acc_op = vfbc_pkg::ACC_LOAD_D;
				end else begin
					ctl.sub = 2'(step_q - 3'd1);
				end
				ctl.mul_en = (step_q >= 3'd1 && step_q <= 3'd3);
				if (step_q >= 3'd2 && step_q <= 3'd4) begin
					ctl.acc_op = vfbc_pkg::ACC_ADD;
				end
				ctl.vis_check = (step_q == 3'd5);
			end
			vfbc_pkg::ST_DONE: ctl.out_load = !out_valid_q || !out_stall;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vfbc_pkg::ST_IDLE;
			step_q      <= '0;
			elem_q      <= '0;
			plane_q     <= '0;
			sub_q       <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				vfbc_pkg::ST_IDLE: begin
					step_q  <= '0;
					elem_q  <= '0;
					plane_q <= '0;
					sub_q   <= '0;
					iter_q  <= '0;
				end
				vfbc_pkg::ST_MAT: begin
					if (step_q == 3'd5) begin
						step_q <= '0;
						elem_q <= elem_q + 4'd1;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				vfbc_pkg::ST_EXT: step_q <= step_q + 3'd1;
				vfbc_pkg::ST_SQ: begin
					if (step_q == 3'd3) begin
						step_q <= '0;
						iter_q <= '0;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				vfbc_pkg::ST_SQRT: begin
					if (iter_q == ITER_W'(vfbc_pkg::SQRT_STEPS)) begin
						iter_q <= '0;
						sub_q  <= '0;
					end else begin
						iter_q <= iter_q + ITER_W'(1);
					end
				end
				vfbc_pkg::ST_DIV: begin
					if (iter_q == '0 && status.len_zero) begin
						iter_q <= '0;
					end else if (div_last) begin
						iter_q <= '0;
						sub_q  <= sub_q + 2'd1;
						if (sub_q == 2'd3) begin
							plane_q <= plane_q + 3'd1;
							step_q  <= '0;
						end
					end else begin
						iter_q <= iter_q + ITER_W'(1);
					end
				end
				vfbc_pkg::ST_ZERO: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) begin
						plane_q <= plane_q + 3'd1;
						step_q  <= '0;
					end
				end
				vfbc_pkg::ST_TEST: begin
					if (step_q == 3'd5) begin
						step_q  <= '0;
						plane_q <= plane_q + 3'd1;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				default: step_q <= step_q;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`VFBC_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall)
	`VFBC_ASSERT_NEXT(a_load_shows_result, ctl.out_load, out_valid)
	`VFBC_ASSERT_NOW(a_load_slot_free, ctl.out_load, !out_valid_q || !out_stall)
	`VFBC_ASSERT_NOW(a_test_plane_range, state_q == vfbc_pkg::ST_TEST, !(plane_q > 3'd5))
	`VFBC_ASSERT_NOW(a_div_iter_range, state_q == vfbc_pkg::ST_DIV, !(iter_q > ITER_W'(DIV_STEPS + 1)))

endmodule

// ===== dv/view_frustum_box_culler_tb.sv =====
// Self-checking testbench for the view frustum box culler: queued stimulus, predictor, checker.
`timescale 1ns / 1ps

module view_frustum_box_culler_tb;

	localparam int FB = vfbc_pkg::FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic signed [31:0] ONE = 32'sd65536;

	typedef struct {
		vfbc_pkg::cmd_t     op;
		logic              msel;
		logic [3:0]        idx;
		logic signed [31:0] val;
		logic signed [31:0] bnd [6];
		logic              drain;
	} item_t;

	typedef struct packed {
		logic vis;
		logic deg;
		logic sat;
	} verdict_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] cmd;
	logic matrix_select;
	logic [3:0] element_index;
	logic signed [31:0] element_value;
	logic signed [31:0] box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z;
	logic in_view, degenerate_plane, saturated;

	view_frustum_box_culler DUT (.*);

	item_t pending [$];
	verdict_t verdicts [$];
	item_t cur;
	int gap, hold, nsent, nseen, mismatches, cycles;

	// Predictor state.
	logic signed [31:0] mv [16];
	logic signed [31:0] pr [16];
	logic signed [31:0] planes [24];
	logic deg_flag, clamped;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp32(input logic signed [67:0] v);
		if (v > 68'sh7FFFFFFF) begin
			clamped = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (v < -68'sh80000000) begin
			clamped = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] res, bt;
		res = '0;
		bt = 64'h4000_0000_0000_0000;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] normalize(input logic signed [31:0] x,
			input logic [63:0] len);
		logic [63:0] mag, q;
		logic signed [67:0] s;
		mag = (x < 0) ? 64'(-(68'(x))) : 64'(x);
		q = (mag << FB) / len;
		s = (x < 0) ? -$signed({4'b0, q}) : $signed({4'b0, q});
		return clamp32(s);
	endfunction

	task automatic build_planes();
		logic signed [31:0] clip [16];
		logic signed [31:0] co [4];
		logic signed [67:0] acc;
		logic signed [63:0] w;
		logic [63:0] sq, len;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				acc = '0;
				for (int k = 0; k < 4; k++)
					acc += 68'(mv[r * 4 + k]) * 68'(pr[k * 4 + c]);
				clip[r * 4 + c] = clamp32(acc >>> FB);
			end
		deg_flag = 1'b0;
		for (int p = 0; p < 6; p++) begin
			for (int r = 0; r < 4; r++) begin
				// Column 3 plus or minus column 0, 1 or 2, depending on the plane.
				if (p == 1 || p == 2 || p == 5)
					acc = 68'(clip[r * 4 + 3]) + 68'(clip[r * 4 + p / 2]);
				else
					acc = 68'(clip[r * 4 + 3]) - 68'(clip[r * 4 + p / 2]);
				co[r] = clamp32(acc);
			end
			sq = '0;
			for (int r = 0; r < 3; r++) begin
				w = co[r];
				sq += w * w;
			end
			len = floor_sqrt(sq);
			if (len == 0) deg_flag = 1'b1;
			for (int r = 0; r < 4; r++)
				planes[p * 4 + r] = (len == 0) ? 32'sd0 : normalize(co[r], len);
		end
	endtask

	function automatic logic box_visible(input item_t it);
		logic signed [67:0] acc;
		logic signed [31:0] pt [3];
		logic any;
		for (int p = 0; p < 6; p++) begin
			any = 1'b0;
			for (int k = 0; k < 8; k++) begin
				for (int a = 0; a < 3; a++)
					pt[a] = k[a] ? it.bnd[3 + a] : it.bnd[a];
				acc = 68'(planes[p * 4 + 3]) <<< FB;
				for (int a = 0; a < 3; a++)
					acc += 68'(planes[p * 4 + a]) * 68'(pt[a]);
				if (acc > 0) any = 1'b1;
			end
			if (!any) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic predict(input item_t it);
		verdict_t v;
		clamped = 1'b0;
		v.vis = 1'b0;
		case (it.op)
			vfbc_pkg::CMD_LOAD: begin
				if (it.msel) pr[it.idx] = it.val;
				else mv[it.idx] = it.val;
			end
			vfbc_pkg::CMD_BUILD: build_planes();
			vfbc_pkg::CMD_TEST: v.vis = box_visible(it);
			default: ;
		endcase
		v.deg = deg_flag;
		v.sat = clamped;
		verdicts.push_back(v);
	endtask

	function automatic logic signed [31:0] rnd_elem();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'sd0;
			2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed($urandom_range(0, 262144)) - 32'sd131072;
		endcase
	endfunction

	task automatic push(input vfbc_pkg::cmd_t op, input logic msel, input logic [3:0] idx,
			input logic signed [31:0] val, input logic drain);
		item_t it;
		it.op = op;
		it.msel = msel;
		it.idx = idx;
		it.val = val;
		it.drain = drain;
		for (int a = 0; a < 6; a++) it.bnd[a] = $urandom;
		pending.push_back(it);
	endtask

	task automatic push_box(input logic signed [31:0] lo [3], input logic signed [31:0] hi [3]);
		item_t it;
		it.op = vfbc_pkg::CMD_TEST;
		it.msel = $urandom;
		it.idx = $urandom;
		it.val = $urandom;
		it.drain = 1'b0;
		for (int a = 0; a < 3; a++) begin
			it.bnd[a] = lo[a];
			it.bnd[3 + a] = hi[a];
		end
		pending.push_back(it);
	endtask

	task automatic push_random_box();
		logic signed [31:0] lo [3], hi [3];
		logic signed [31:0] ctr, half;
		for (int a = 0; a < 3; a++) begin
			case ($urandom_range(0, 15))
				0: begin
					lo[a] = $urandom;
					hi[a] = $urandom;
				end
				1: begin
					lo[a] = 32'sh80000000;
					hi[a] = 32'sh7FFFFFFF;
				end
				default: begin
					ctr = $signed($urandom_range(0, 1048576)) - 32'sd524288;
					half = $urandom_range(0, 262144);
					lo[a] = ctr - half;
					hi[a] = ctr + half;
					// Occasionally hand the bounds over swapped.
					if ($urandom_range(0, 19) == 0) begin
						lo[a] = ctr + half;
						hi[a] = ctr - half;
					end
				end
			endcase
		end
		push_box(lo, hi);
	endtask

	// Driver: the next queued item goes out once the previous one is taken and its gap is over.
	always @(posedge clk or negedge arst_n) begin
		logic sent;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= '0;
			matrix_select <= 1'b0;
			element_index <= '0;
			element_value <= '0;
			box_min_x <= '0;
			box_min_y <= '0;
			box_min_z <= '0;
			box_max_x <= '0;
			box_max_y <= '0;
			box_max_z <= '0;
			gap = 0;
			nsent = 0;
			// The predictor starts from the same cleared state as the block.
			foreach (mv[i]) begin
				mv[i] = '0;
				pr[i] = '0;
			end
			foreach (planes[i]) planes[i] = '0;
			deg_flag = 1'b0;
		end else begin
			sent = in_valid && !in_stall;
			if (sent) begin
				predict(cur);
				nsent++;
			end
			if (sent || !in_valid) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (pending.size() > 0 &&
						!(pending[0].drain && verdicts.size() > 0)) begin
					cur = pending.pop_front();
					cmd <= cur.op;
					matrix_select <= cur.msel;
					element_index <= cur.idx;
					element_value <= cur.val;
					box_min_x <= cur.bnd[0];
					box_min_y <= cur.bnd[1];
					box_min_z <= cur.bnd[2];
					box_max_x <= cur.bnd[3];
					box_max_y <= cur.bnd[4];
					box_max_z <= cur.bnd[5];
					in_valid <= 1'b1;
					gap = (nsent[7:6] == 2'b00) ? 0 : $urandom_range(0, 15);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result against the oldest prediction and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		verdict_t exp_v;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold = 0;
			nseen = 0;
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result with no item outstanding: in_view=%0b deg=%0b sat=%0b",
							in_view, degenerate_plane, saturated);
				end else begin
					exp_v = verdicts.pop_front();
					if (exp_v != {in_view, degenerate_plane, saturated}) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Result %0d: expected in_view=%0b deg=%0b sat=%0b, got %0b %0b %0b",
								nseen, exp_v.vis, exp_v.deg, exp_v.sat,
								in_view, degenerate_plane, saturated);
					end
				end
				nseen++;
				hold = (nseen[7:6] == 2'b01) ? 0 : $urandom_range(0, 15);
			end
			out_stall <= (hold != 0);
			if (hold != 0) hold--;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic signed [31:0] lo [3], hi [3];
		arst_n = 1'b0;

		// Directed part: everything is culled before a build, then the unused command and
		// degenerate, identity and saturating matrices.
		lo = '{-ONE, -ONE, -ONE};
		hi = '{ONE, ONE, ONE};
		push_box(lo, hi);
		push(vfbc_pkg::CMD_NOP, 1'b1, 4'hF, 32'sh7FFFFFFF, 1'b0);
		push(vfbc_pkg::CMD_BUILD, 1'b0, 4'h0, 32'sd0, 1'b0);
		for (int i = 0; i < 4; i++) begin
			push(vfbc_pkg::CMD_LOAD, 1'b0, 4'(i * 5), ONE, 1'b0);
			push(vfbc_pkg::CMD_LOAD, 1'b1, 4'(i * 5), ONE, 1'b0);
		end
		push(vfbc_pkg::CMD_BUILD, 1'b0, 4'h0, 32'sd0, 1'b1);
		lo = '{-32768, -32768, -32768};
		hi = '{32768, 32768, 32768};
		push_box(lo, hi);
		lo = '{5 * ONE, 5 * ONE, 5 * ONE};
		hi = '{6 * ONE, 6 * ONE, 6 * ONE};
		push_box(lo, hi);
		lo = '{ONE, ONE, ONE};
		hi = '{-ONE, -ONE, -ONE};
		push_box(lo, hi);
		lo = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
		hi = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
		push_box(lo, hi);
		push(vfbc_pkg::CMD_LOAD, 1'b0, 4'h0, 32'sh7FFFFFFF, 1'b0);
		push(vfbc_pkg::CMD_LOAD, 1'b1, 4'h0, 32'sh80000000, 1'b0);
		push(vfbc_pkg::CMD_LOAD, 1'b1, 4'hF, 32'sh7FFFFFFF, 1'b0);
		push(vfbc_pkg::CMD_BUILD, 1'b0, 4'h0, 32'sd0, 1'b0);
		push_box(lo, hi);

		// Random scenes: rewrite part of the matrices, build, then test a batch of boxes.
		while (pending.size() < 1850) begin
			int nl, nt;
			nl = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(1, 12);
			for (int i = 0; i < nl; i++) begin
				if (nl == 32)
					push(vfbc_pkg::CMD_LOAD, 1'(i / 16), 4'(i), rnd_elem(), 1'b0);
				else
					push(vfbc_pkg::CMD_LOAD, 1'($urandom), 4'($urandom), rnd_elem(), 1'b0);
			end
			push(vfbc_pkg::CMD_BUILD, 1'($urandom), 4'($urandom), $urandom,
				$urandom_range(0, 3) == 0);
			nt = $urandom_range(20, 50);
			for (int i = 0; i < nt; i++) begin
				case ($urandom_range(0, 39))
					0: push(vfbc_pkg::CMD_NOP, 1'($urandom), 4'($urandom), $urandom, 1'b0);
					1: push(vfbc_pkg::CMD_LOAD, 1'($urandom), 4'($urandom), rnd_elem(), 1'b0);
					default: push_random_box();
				endcase
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() > 0 || in_valid || verdicts.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && verdicts.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
